// ===== sv/clmd_pkg.sv =====
// ----------------------------------------------------------------------------
// clmd_pkg
// Shared types, constants and helpers for the Content-Length message deframer.
// ----------------------------------------------------------------------------
package clmd_pkg;

    localparam int LEN_BITS   = 31;
    localparam int LEN_EXT    = LEN_BITS + 4;
    localparam int PREFIX_LEN = 16;

    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_C     = 8'h43;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_HEADER,
        PH_BODY,
        PH_HALT
    } phase_t;

    typedef enum logic [1:0] {
        LP_SEARCH,
        LP_SPACE,
        LP_DIGITS,
        LP_DONE
    } lp_t;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_NO_LEN     = 3'd1,
        ST_BAD_LEN    = 3'd2,
        ST_INCOMPLETE = 3'd3,
        ST_HALTED     = 3'd4
    } status_t;

    // header tracking state
    typedef struct packed {
        logic [1:0]          sep;
        logic [3:0]          pref;
        lp_t                 lp;
        logic [LEN_BITS-1:0] len;
        logic                bad;
    } scan_t;

    localparam scan_t SCAN_CLEAR = '{sep: 2'd0, pref: 4'd0, lp: LP_SEARCH,
                                     len: '0, bad: 1'b0};

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic       in_body;
        logic       last;
        status_t    status;
    } res_t;

    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'h43; // C
            4'd1:    c = 8'h6F; // o
            4'd2:    c = 8'h6E; // n
            4'd3:    c = 8'h74; // t
            4'd4:    c = 8'h65; // e
            4'd5:    c = 8'h6E; // n
            4'd6:    c = 8'h74; // t
            4'd7:    c = 8'h2D; // -
            4'd8:    c = 8'h4C; // L
            4'd9:    c = 8'h65; // e
            4'd10:   c = 8'h6E; // n
            4'd11:   c = 8'h67; // g
            4'd12:   c = 8'h74; // t
            4'd13:   c = 8'h68; // h
            4'd14:   c = 8'h3A; // :
            default: c = 8'h20; // space
        endcase
        return c;
    endfunction

    function automatic logic is_space(input logic [7:0] b);
        return (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
    endfunction

endpackage

// ===== sv/clmd_hdr_scan.sv =====
// ----------------------------------------------------------------------------
// clmd_hdr_scan
// Header byte scanner: separator match, prefix match and length digits.
// ----------------------------------------------------------------------------
module clmd_hdr_scan (
    input  logic [7:0]     data_byte,
    input  clmd_pkg::scan_t cur,
    output clmd_pkg::scan_t nxt,
    output logic           sep_close
);
    import clmd_pkg::*;

    logic                digit;
    logic [3:0]          dval;
    logic [LEN_EXT-1:0]  len_ext;
    logic [LEN_EXT-1:0]  prod;

    assign digit   = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
    // ASCII digits carry their value in the low nibble
    assign dval    = data_byte[3:0];
    assign len_ext = {4'b0000, cur.len};
    // times ten as shift and add
    assign prod    = (len_ext << 3) + (len_ext << 1) + {{(LEN_EXT-4){1'b0}}, dval};

    always_comb
    begin
        nxt       = cur;
        sep_close = 1'b0;

        // CR LF CR LF tracking
        if (data_byte == CHAR_CR)
        begin
            nxt.sep = (cur.sep == 2'd2) ? 2'd3 : 2'd1;
        end
        else if ((data_byte == CHAR_LF) && ((cur.sep == 2'd1) || (cur.sep == 2'd3)))
        begin
            if (cur.sep == 2'd3)
                sep_close = 1'b1;
            else
                nxt.sep = 2'd2;
        end
        else
        begin
            nxt.sep = 2'd0;
        end

        // length header tracking
        case (cur.lp)
            LP_SEARCH:
            begin
                if (data_byte == prefix_char(cur.pref))
                begin
                    if (cur.pref == 4'(PREFIX_LEN - 1))
                    begin
                        nxt.pref = 4'd0;
                        nxt.lp   = LP_SPACE;
                    end
                    else
                    begin
                        nxt.pref = cur.pref + 4'd1;
                    end
                end
                else
                begin
                    nxt.pref = (data_byte == CHAR_C) ? 4'd1 : 4'd0;
                end
            end
            LP_SPACE:
            begin
                if (digit)
                begin
                    nxt.len = {{(LEN_BITS-4){1'b0}}, dval};
                    nxt.lp  = LP_DIGITS;
                end
                else if (!is_space(data_byte))
                begin
                    nxt.bad = 1'b1;
                    nxt.lp  = LP_DONE;
                end
            end
            LP_DIGITS:
            begin
                if (digit)
                begin
                    if (prod[LEN_EXT-1:LEN_BITS] != 4'd0)
                    begin
                        nxt.bad = 1'b1;
                        nxt.lp  = LP_DONE;
                    end
                    else
                    begin
                        nxt.len = prod[LEN_BITS-1:0];
                    end
                end
                else
                begin
                    nxt.lp = LP_DONE;
                end
            end
            default:
            begin
                nxt.lp = cur.lp;
            end
        endcase
    end

endmodule

// ===== sv/clmd_ctrl.sv =====
// ----------------------------------------------------------------------------
// clmd_ctrl
// Framing state machine: message phase, header tracking and body count.
// ----------------------------------------------------------------------------
module clmd_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  logic [7:0]    data_byte,
    input  logic          stream_end,
    output clmd_pkg::res_t res
);
    import clmd_pkg::*;

    phase_t              phase_reg, phase_next;
    scan_t               scan_reg, scan_next;
    logic [LEN_BITS-1:0] remain_reg, remain_next;

    scan_t               scan_upd;
    logic                sep_close;
    logic                no_len;
    logic                bad_len;
    logic                body_final;

    clmd_hdr_scan u_scan (
        .data_byte (data_byte),
        .cur       (scan_reg),
        .nxt       (scan_upd),
        .sep_close (sep_close)
    );

    assign no_len     = (scan_reg.lp == LP_SEARCH);
    assign bad_len    = scan_reg.bad || (scan_reg.lp == LP_SPACE);
    assign body_final = (remain_reg == {{(LEN_BITS-1){1'b0}}, 1'b1});

    // next state
    always_comb
    begin
        phase_next  = phase_reg;
        scan_next   = scan_reg;
        remain_next = remain_reg;
        if (accept)
        begin
            case (phase_reg)
                PH_HALT:
                begin
                    phase_next = PH_HALT;
                end
                PH_BODY:
                begin
                    if (stream_end)
                        phase_next = PH_HALT;
                    else
                    begin
                        remain_next = remain_reg - {{(LEN_BITS-1){1'b0}}, 1'b1};
                        if (body_final)
                            phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    if (stream_end)
                    begin
                        if (phase_reg == PH_HEADER)
                            phase_next = PH_HALT;
                    end
                    else if (sep_close)
                    begin
                        if (no_len || bad_len)
                            phase_next = PH_HALT;
                        else
                        begin
                            remain_next = scan_reg.len;
                            scan_next   = SCAN_CLEAR;
                            phase_next  = (scan_reg.len == '0) ? PH_IDLE : PH_BODY;
                        end
                    end
                    else
                    begin
                        phase_next = PH_HEADER;
                        scan_next  = scan_upd;
                    end
                end
            endcase
        end
    end

    // result of the item presented now
    always_comb
    begin
        res = '{data: 8'd0, in_body: 1'b0, last: 1'b0, status: ST_OK};
        case (phase_reg)
            PH_HALT:
            begin
                res.status = ST_HALTED;
            end
            PH_BODY:
            begin
                if (stream_end)
                    res.status = ST_INCOMPLETE;
                else
                begin
                    res.data    = data_byte;
                    res.in_body = 1'b1;
                    res.last    = body_final;
                end
            end
            default:
            begin
                if (stream_end)
                begin
                    if (phase_reg == PH_HEADER)
                        res.status = ST_INCOMPLETE;
                end
                else
                begin
                    res.data = data_byte;
                    if (sep_close)
                    begin
                        if (no_len)
                            res.status = ST_NO_LEN;
                        else if (bad_len)
                            res.status = ST_BAD_LEN;
                        else
                            res.last = (scan_reg.len == '0);
                    end
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_IDLE;
            scan_reg   <= SCAN_CLEAR;
            remain_reg <= '0;
        end
        else
        begin
            phase_reg  <= phase_next;
            scan_reg   <= scan_next;
            remain_reg <= remain_next;
        end
    end

endmodule

// ===== sv/clmd_out_reg.sv =====
// ----------------------------------------------------------------------------
// clmd_out_reg
// Result register with stream handshake toward the downstream side.
// ----------------------------------------------------------------------------
module clmd_out_reg (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  clmd_pkg::res_t res,
    output logic           can_load,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [7:0]     m_axis_tdata,
    output logic           m_axis_tlast,
    output logic [3:0]     m_axis_tuser
);
    import clmd_pkg::*;

    logic valid_reg, valid_next;
    res_t res_reg;

    assign can_load   = !valid_reg || m_axis_tready;
    assign valid_next = load ? 1'b1 : (valid_reg && !m_axis_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res;
    end

    assign m_axis_tvalid = valid_reg;
    assign m_axis_tdata  = res_reg.data;
    assign m_axis_tlast  = res_reg.last;
    assign m_axis_tuser  = {res_reg.status, res_reg.in_body};

endmodule

// ===== sv/content_length_message_deframer.sv =====
// A result is registered and appears on the output in the cycle after its item is accepted.
// Throughput: one item per cycle; s_axis_tready stays high while the output
// register is empty or being drained in the same cycle.
// Reset (rst_n low, asynchronous): back to the idle phase between messages,
// header tracking cleared, output register emptied.
// ----------------------------------------------------------------------------
// content_length_message_deframer
// Splits a byte stream into header/body messages framed by a Content-Length
// header and tags each byte with its role, message end and a status code.
// ----------------------------------------------------------------------------
module content_length_message_deframer (
    input  logic       clk,
    input  logic       rst_n,
    // input item stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tuser,   // [0] stream_end
    // result item stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic       m_axis_tlast,   // last byte of a complete message
    output logic [3:0] m_axis_tuser    // [0] in_body, [3:1] status
);
    import clmd_pkg::*;

    logic accept;
    logic can_load;
    res_t res;

    // take an item whenever the result register can hold its result
    assign s_axis_tready = can_load;
    assign accept        = s_axis_tvalid && can_load;

    // framing logic: the state advances only on an accepted item
    clmd_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .data_byte  (s_axis_tdata),
        .stream_end (s_axis_tuser),
        .res        (res)
    );

    // result register: hold the result until downstream takes it
    clmd_out_reg u_out (
        .clk           (clk),
        .rst_n         (rst_n),
        .load          (accept),
        .res           (res),
        .can_load      (can_load),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// ===== sv/clmd_checker.sv =====
// ----------------------------------------------------------------------------
// clmd_checker
// Port-level checks for the deframer, bound to the top level.
// ----------------------------------------------------------------------------
module clmd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast,
    input logic [3:0] m_axis_tuser
);
    import clmd_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast)
             && $stable(m_axis_tuser)))
        else $error("result changed while stalled");

    // a new result only follows an accepted item
    a_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("result without an accepted item");

    // an empty result register never blocks input
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // body bytes and message ends carry an ok status
    a_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && (m_axis_tlast || m_axis_tuser[0])) |->
            (m_axis_tuser[3:1] == ST_OK))
        else $error("body or last flag with error status");

    // end and halt reports carry no byte
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && ((m_axis_tuser[3:1] == ST_INCOMPLETE)
                           || (m_axis_tuser[3:1] == ST_HALTED))) |->
            ((m_axis_tdata == 8'd0) && !m_axis_tlast && !m_axis_tuser[0]))
        else $error("halt report carries data");

endmodule

bind content_length_message_deframer clmd_checker u_clmd_checker (.*);
